// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the verification checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed.");

// Antecedent implies consequent in the following cycle, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed.");

`endif

// ===== rtl/pvdt_pkg.sv =====
// ---------------------------------------------------------------------------
// Power vote dirty tracker package
// Types, sizes and codes shared by the tracker modules.
// ---------------------------------------------------------------------------
package pvdt_pkg;

    localparam int NUM_RESOURCES = 64;
    localparam int NUM_DRIVERS   = 4;
    localparam int ENTRIES       = NUM_RESOURCES * NUM_DRIVERS;
    localparam int ADDR_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] SET_ACTIVE = 2'd0;
    localparam logic [1:0] SET_SLEEP  = 2'd1;
    localparam logic [1:0] SET_WAKE   = 2'd2;

    localparam logic [1:0] ST_CLEAN        = 2'd0;
    localparam logic [1:0] ST_EXPLICIT     = 2'd1;
    localparam logic [1:0] ST_DIRTY        = 2'd2;
    localparam logic [1:0] ST_DIRTY_ACTIVE = 2'd3;

    typedef struct packed {
        logic [5:0]  resource_index;
        logic [1:0]  driver_index;
        logic [1:0]  vote_set;
        logic [31:0] vote_data;
        logic        wants_completion;
        logic        explicit_vote;
        logic        sent_valid;
        logic [31:0] sent_data;
    } req_t;

    typedef struct packed {
        logic       needs_send;
        logic [1:0] active_state;
        logic [1:0] sleep_state;
        logic [1:0] wake_state;
    } rsp_t;

    typedef struct packed {
        logic [31:0] data;
        logic        valid;
        logic        completion;
        logic [1:0]  dirty;
    } vote_t;

    typedef struct packed {
        vote_t wake;
        vote_t sleep;
        vote_t active;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

// ===== rtl/pvdt_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ---------------------------------------------------------------------------
module pvdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/pvdt_ctrl.sv =====
// ---------------------------------------------------------------------------
// Tracker controller
// Sequences the table read and the update with write-back of one entry.
// ---------------------------------------------------------------------------
module pvdt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    output pvdt_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        IDLE = 2'b01,
        EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = EXEC;
                end
            end
            EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
        done_next = cmd.exec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != IDLE);
    assign done = done_reg;

endmodule

// ===== rtl/pvdt_datapath.sv =====
// ---------------------------------------------------------------------------
// Tracker datapath
// Holds the vote table and the request, reconciles the dirty states of one
// entry and writes the entry back.
// ---------------------------------------------------------------------------
module pvdt_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pvdt_pkg::ctrl_cmd_t  cmd,
    input  pvdt_pkg::req_t       req,
    output pvdt_pkg::rsp_t       rsp
);

    pvdt_pkg::req_t                 req_reg;
    pvdt_pkg::rsp_t                 rsp_reg;
    pvdt_pkg::rsp_t                 rsp_next;
    logic [pvdt_pkg::ENTRIES-1:0]   row_valid_reg;
    logic                           hit_reg;
    logic [pvdt_pkg::ADDR_W-1:0]    rd_addr;
    logic [pvdt_pkg::ADDR_W-1:0]    wr_addr;
    logic                           wr_en;
    logic [pvdt_pkg::ENTRY_W-1:0]   rd_data;
    pvdt_pkg::entry_t               cur;
    pvdt_pkg::entry_t               upd;
    pvdt_pkg::entry_t               fin;
    logic                           in_range;
    logic                           set_ok;

    function automatic logic [pvdt_pkg::ADDR_W-1:0] row_addr(logic [5:0] res, logic [1:0] drv);
        row_addr = pvdt_pkg::ADDR_W'(int'(res) * pvdt_pkg::NUM_DRIVERS + int'(drv));
    endfunction

    function automatic pvdt_pkg::vote_t store_vote(pvdt_pkg::vote_t v, logic [31:0] data,
                                                   logic make_explicit);
        pvdt_pkg::vote_t r;
        r       = v;
        r.data  = data;
        r.valid = 1'b1;
        if (make_explicit)
        begin
            r.dirty = pvdt_pkg::ST_EXPLICIT;
        end
        return r;
    endfunction

    function automatic pvdt_pkg::entry_t reconcile(pvdt_pkg::entry_t e, logic comp,
                                                   logic sent_ok, logic [31:0] sent_d);
        pvdt_pkg::entry_t r;
        r = e;
        if (r.active.valid && (!sent_ok || r.active.data != sent_d ||
                               (comp && !r.active.completion)))
        begin
            r.active.dirty = pvdt_pkg::ST_DIRTY;
        end
        else
        begin
            r.active.dirty = pvdt_pkg::ST_CLEAN;
        end
        if (r.sleep.dirty != pvdt_pkg::ST_EXPLICIT)
        begin
            if (r.sleep.valid && (!r.active.valid || r.active.data != r.sleep.data))
            begin
                r.sleep.dirty = pvdt_pkg::ST_DIRTY;
            end
            else
            begin
                r.sleep.dirty = pvdt_pkg::ST_CLEAN;
            end
        end
        if (r.wake.dirty != pvdt_pkg::ST_EXPLICIT)
        begin
            if (r.wake.valid && ((r.active.valid && r.wake.data != r.active.data) ||
                                 (r.sleep.valid && r.wake.data != r.sleep.data)))
            begin
                r.wake.dirty = pvdt_pkg::ST_DIRTY;
            end
            else if (!r.wake.valid && r.active.valid && r.sleep.valid &&
                     r.active.data != r.sleep.data &&
                     r.sleep.dirty != pvdt_pkg::ST_EXPLICIT)
            begin
                r.wake.dirty = pvdt_pkg::ST_DIRTY_ACTIVE;
            end
            else
            begin
                r.wake.dirty = pvdt_pkg::ST_CLEAN;
            end
        end
        return r;
    endfunction

    assign rd_addr = row_addr(req.resource_index, req.driver_index);
    assign wr_addr = row_addr(req_reg.resource_index, req_reg.driver_index);

    pvdt_ram #(
        .WIDTH (pvdt_pkg::ENTRY_W),
        .DEPTH (pvdt_pkg::ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (fin),
        .rd_en   (cmd.load),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        in_range = (int'(req_reg.resource_index) < pvdt_pkg::NUM_RESOURCES) &&
                   (int'(req_reg.driver_index) < pvdt_pkg::NUM_DRIVERS);
        cur      = hit_reg ? pvdt_pkg::entry_t'(rd_data) : '0;
        upd      = cur;
        set_ok   = 1'b1;
        case (req_reg.vote_set)
            pvdt_pkg::SET_ACTIVE:
            begin
                upd.active = store_vote(cur.active, req_reg.vote_data, 1'b0);
            end
            pvdt_pkg::SET_SLEEP:
            begin
                upd.sleep = store_vote(cur.sleep, req_reg.vote_data, req_reg.explicit_vote);
            end
            pvdt_pkg::SET_WAKE:
            begin
                upd.wake = store_vote(cur.wake, req_reg.vote_data, req_reg.explicit_vote);
            end
            default:
            begin
                set_ok = 1'b0;
            end
        endcase

        fin = cur;
        rsp_next.needs_send = 1'b0;
        if (set_ok)
        begin
            fin = reconcile(upd,
                            req_reg.wants_completion && (req_reg.vote_set == pvdt_pkg::SET_ACTIVE),
                            req_reg.sent_valid, req_reg.sent_data);
            case (req_reg.vote_set)
                pvdt_pkg::SET_ACTIVE:
                begin
                    fin.active.completion = req_reg.wants_completion;
                    rsp_next.needs_send   = fin.active.dirty[1];
                end
                pvdt_pkg::SET_SLEEP:
                begin
                    fin.sleep.completion = req_reg.wants_completion;
                    rsp_next.needs_send  = fin.sleep.dirty[1];
                end
                default:
                begin
                    fin.wake.completion = req_reg.wants_completion;
                    rsp_next.needs_send = fin.wake.dirty[1];
                end
            endcase
        end
        rsp_next.active_state = fin.active.dirty;
        rsp_next.sleep_state  = fin.sleep.dirty;
        rsp_next.wake_state   = fin.wake.dirty;
        if (!in_range)
        begin
            rsp_next = '0;
        end
        wr_en = cmd.exec && in_range && set_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            row_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
            hit_reg <= row_valid_reg[rd_addr];
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== rtl/power_vote_dirty_tracker_top.sv =====
// Timing: a transaction accepted at a clock edge while busy is low has its request and table
// entry registered at that edge, and then its result registered on rsp with done set.
// Acceptance: start is taken only while busy is low; each transaction reads one table entry
// and writes it back in the following cycle.
// Reset: rst_n clears the controller and every row valid bit at once; rows read as
// clean, invalid and zero until first written.
// ---------------------------------------------------------------------------
// Power vote dirty tracker top level
// Stores active, sleep and wake votes per resource and driver and reports
// the reconciled dirty states for each transaction.
// ---------------------------------------------------------------------------
module power_vote_dirty_tracker_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  pvdt_pkg::req_t  req,
    output logic            done,
    output pvdt_pkg::rsp_t  rsp
);

    pvdt_pkg::ctrl_cmd_t cmd;

    pvdt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    pvdt_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// ===== rtl/pvdt_checker.sv =====
// ---------------------------------------------------------------------------
// Tracker port checker
// Checks the transaction timing seen on the top-level ports.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pvdt_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMPLIES(a_accept_done, clk, rst_n, start && !busy, ##2 done)
    `ASSERT_IMPLIES(a_done_idle, clk, rst_n, done, !busy)
    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)

endmodule

bind power_vote_dirty_tracker_top pvdt_checker u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
